### hw/rtl/uer_pkg.sv
// ---------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and register indexes of the ultrasonic echo ranger.
// ---------------------------------------------------------------------------
package uer_pkg;

  // Trigger pulse shape and echo width scale, in ticks.
  localparam int TRIGGER_LOW_TICKS  = 4;
  localparam int TRIGGER_HIGH_TICKS = 10;
  localparam int TICKS_PER_CM       = 58;

  // Field and counter widths.
  localparam int CNT_W       = 16;
  localparam int SINCE_W     = 20;
  localparam int DIST_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int MAXDIST_W   = 10;
  localparam int HOLDOFF_W   = 20;
  localparam int WAIT_W      = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  // Reciprocal for the exact division of a CNT_W-bit width by TICKS_PER_CM.
  localparam int     DIV_SHIFT  = CNT_W + $clog2(TICKS_PER_CM);
  localparam int     DIV_MULT_W = CNT_W + 1;
  localparam longint DIV_MULT   =
    ((longint'(1) << DIV_SHIFT) + TICKS_PER_CM - 1) / TICKS_PER_CM;
  localparam int     DIV_PROD_W = DIV_SHIFT + CNT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_WAIT    = 2'd2;

  // Configuration reset values.
  localparam logic [MAXDIST_W-1:0] MAX_DISTANCE_RESET = 10'd400;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET      = 20'd0;
  localparam logic [WAIT_W-1:0]    ECHO_WAIT_RESET    = 16'd6000;

  // Completion status codes.
  localparam logic [STATUS_W-1:0] STATUS_FRESH     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CACHED    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ECHO_BUSY = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_ECHO   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 3'd4;

  // One tick of input.
  typedef struct packed {
    logic start_request;
    logic echo_level;
  } tick_t;

  // One result per tick.
  typedef struct packed {
    logic                trigger_level;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_cm;
  } result_t;

  // Configuration as seen by the controller.
  typedef struct packed {
    logic [MAXDIST_W-1:0] max_distance_cm;
    logic [HOLDOFF_W-1:0] holdoff_ticks;
    logic [WAIT_W-1:0]    echo_wait_ticks;
    logic [CNT_W-1:0]     echo_limit;
  } cfg_t;

  // Echo width limit in ticks, clamped to the counter range.
  function automatic logic [CNT_W-1:0] echo_limit_of(input logic [MAXDIST_W-1:0] dist_cm);
    logic [MAXDIST_W+8-1:0] prod;
    prod = {8'd0, dist_cm} * (MAXDIST_W + 8)'(TICKS_PER_CM);
    if (prod > (MAXDIST_W + 8)'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return prod[CNT_W-1:0];
  endfunction

endpackage

### hw/rtl/uer_cfg_regs.sv
// ---------------------------------------------------------------------------
// uer_cfg_regs
// Configuration registers with the derived echo width limit.
// ---------------------------------------------------------------------------
module uer_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  output uer_pkg::cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file; the limit is recomputed whenever the distance is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance_cm <= uer_pkg::MAX_DISTANCE_RESET;
      cfg.holdoff_ticks   <= uer_pkg::HOLDOFF_RESET;
      cfg.echo_wait_ticks <= uer_pkg::ECHO_WAIT_RESET;
      cfg.echo_limit      <= uer_pkg::echo_limit_of(uer_pkg::MAX_DISTANCE_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uer_pkg::REG_MAX_DISTANCE: begin
          cfg.max_distance_cm <= cfg_data[uer_pkg::MAXDIST_W-1:0];
          cfg.echo_limit      <= uer_pkg::echo_limit_of(cfg_data[uer_pkg::MAXDIST_W-1:0]);
        end
        uer_pkg::REG_HOLDOFF: begin
          cfg.holdoff_ticks <= cfg_data[uer_pkg::HOLDOFF_W-1:0];
        end
        uer_pkg::REG_ECHO_WAIT: begin
          cfg.echo_wait_ticks <= cfg_data[uer_pkg::WAIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/uer_div.sv
// ---------------------------------------------------------------------------
// uer_div
// Converts an echo width in ticks to centimetres by a reciprocal multiply.
// ---------------------------------------------------------------------------
module uer_div (
  input  logic [uer_pkg::CNT_W-1:0]  width,
  output logic [uer_pkg::DIST_W-1:0] dist_cm
);

  logic [uer_pkg::DIV_PROD_W-1:0] prod;

  // The rounded-up reciprocal gives the exact quotient over the counter range.
  assign prod = uer_pkg::DIV_PROD_W'(width)
              * uer_pkg::DIV_PROD_W'(uer_pkg::DIV_MULT[uer_pkg::DIV_MULT_W-1:0]);
  assign dist_cm = prod[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W];

endmodule

### hw/rtl/ultrasonic_echo_ranger_core.sv
// An accepted tick's result is written into the output register when the tick is taken.
// Throughput: one tick per cycle while res_ready is high; the output register refills as it drains.
// Every tick gives exactly one result, set by the single controller state update.
// Reset (rst, synchronous) returns to idle, clears the stored distance and the
// result valid flag, saturates the hold-off count, and reloads the register defaults.
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Trigger pulse generation, echo timing and cached distance answers.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_ready,
  input  uer_pkg::tick_t                 tick,
  output logic                           res_valid,
  input  logic                           res_ready,
  output uer_pkg::result_t               res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TLOW,
    PH_THIGH,
    PH_CHECK,
    PH_WAIT,
    PH_WIDTH
  } phase_t;

  uer_pkg::cfg_t                  cfg;
  phase_t                         phase, phase_next;
  logic [uer_pkg::CNT_W-1:0]      phase_counter, phase_counter_next;
  logic [uer_pkg::SINCE_W-1:0]    since_last, since_last_next;
  logic [uer_pkg::DIST_W-1:0]     stored_distance, stored_distance_next;
  uer_pkg::result_t               res_next;
  logic [uer_pkg::CNT_W-1:0]      count_inc;
  logic [uer_pkg::CNT_W-1:0]      count_sat;
  logic [uer_pkg::DIST_W-1:0]     width_cm;
  logic                           fresh_start;
  logic                           accept;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_div u_div (
    .width   (phase_counter),
    .dist_cm (width_cm)
  );

  // A tick is taken whenever the result register is empty or being drained.
  assign tick_ready = !res_valid || res_ready;
  assign accept     = tick_valid && tick_ready;

  assign count_inc = phase_counter + 1'b1;
  assign count_sat = (phase_counter < uer_pkg::CNT_MAX) ? count_inc : phase_counter;

  // Controller next state and the result of the current tick.
  always_comb begin
    phase_next           = phase;
    phase_counter_next   = phase_counter;
    stored_distance_next = stored_distance;
    fresh_start          = 1'b0;
    res_next             = '0;
    unique case (phase)
      PH_IDLE: begin
        if (tick.start_request) begin
          if (since_last < cfg.holdoff_ticks) begin
            res_next.done_res    = 1'b1;
            res_next.status      = uer_pkg::STATUS_CACHED;
            res_next.distance_cm = stored_distance;
          end else begin
            fresh_start        = 1'b1;
            phase_next         = PH_TLOW;
            phase_counter_next = '0;
          end
        end
      end
      PH_TLOW: begin
        if (count_inc >= uer_pkg::CNT_W'(uer_pkg::TRIGGER_LOW_TICKS)) begin
          phase_next         = PH_THIGH;
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc;
        end
      end
      PH_THIGH: begin
        res_next.trigger_level = 1'b1;
        if (count_inc >= uer_pkg::CNT_W'(uer_pkg::TRIGGER_HIGH_TICKS)) begin
          phase_next         = PH_CHECK;
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc;
        end
      end
      PH_CHECK: begin
        if (tick.echo_level) begin
          res_next.done_res = 1'b1;
          res_next.status   = uer_pkg::STATUS_ECHO_BUSY;
          phase_next        = PH_IDLE;
        end else begin
          phase_next         = PH_WAIT;
          phase_counter_next = uer_pkg::CNT_W'(1);
        end
      end
      PH_WAIT: begin
        if (tick.echo_level) begin
          phase_counter_next = '0;
          if (cfg.echo_limit == '0) begin
            res_next.done_res = 1'b1;
            res_next.status   = uer_pkg::STATUS_TOO_LONG;
            phase_next        = PH_IDLE;
          end else begin
            phase_next = PH_WIDTH;
          end
        end else if (phase_counter >= cfg.echo_wait_ticks) begin
          res_next.done_res = 1'b1;
          res_next.status   = uer_pkg::STATUS_NO_ECHO;
          phase_next        = PH_IDLE;
        end else begin
          phase_counter_next = count_inc;
        end
      end
      PH_WIDTH: begin
        if (tick.echo_level) begin
          phase_counter_next = count_sat;
          if (count_sat >= cfg.echo_limit) begin
            res_next.done_res = 1'b1;
            res_next.status   = uer_pkg::STATUS_TOO_LONG;
            phase_next        = PH_IDLE;
          end
        end else begin
          res_next.done_res    = 1'b1;
          res_next.status      = uer_pkg::STATUS_FRESH;
          res_next.distance_cm = width_cm;
          stored_distance_next = width_cm;
          phase_next           = PH_IDLE;
        end
      end
      default: begin
        phase_next         = PH_IDLE;
        phase_counter_next = '0;
      end
    endcase

    // Ticks since the last fresh start, saturating.
    if (fresh_start) begin
      since_last_next = uer_pkg::SINCE_W'(1);
    end else if (since_last < uer_pkg::SINCE_MAX) begin
      since_last_next = since_last + 1'b1;
    end else begin
      since_last_next = since_last;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_counter   <= '0;
      since_last      <= uer_pkg::SINCE_MAX;
      stored_distance <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        phase_counter   <= phase_counter_next;
        since_last      <= since_last_next;
        stored_distance <= stored_distance_next;
        res             <= res_next;
        res_valid       <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
